// File: rtl/core/pps_pkg.sv
// Package for the preemptive priority scheduler.
// Request and result types, field widths, saturation limits and codes.
// No dependencies.
package pps_pkg;

	localparam int TIME_W  = 20;
	localparam int TOTAL_W = 24;
	localparam int CNT_W   = 4;

	localparam logic [TIME_W-1:0]  TIME_MAX  = {TIME_W{1'b1}};
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic REG_TASK_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] TASK_COUNT_RESET = 4'd8;

	typedef struct packed {
		logic        mode;
		logic [2:0]  slot;
		logic [7:0]  task_tag;
		logic [7:0]  task_priority;
		logic [15:0] burst_length;
		logic [15:0] arrival_tick;
	} req_t;

	typedef struct packed {
		logic               ran_valid;
		logic [2:0]         ran_slot;
		logic [7:0]         ran_tag;
		logic               finished;
		logic [TIME_W-1:0]  wait_ticks;
		logic [TIME_W-1:0]  turnaround_ticks;
		logic               all_done;
		logic [TIME_W-1:0]  time_now;
		logic [TOTAL_W-1:0] sum_wait;
		logic [TOTAL_W-1:0] sum_turnaround;
	} rsp_t;

endpackage

// File: rtl/core/preemptive_priority_scheduler_top.sv
// Top level of the preemptive priority scheduler.
// Depends on pps_pkg, pps_regs and pps_core.
//
// Request channel: a request is taken at a rising edge with start high and
// busy low. busy is always low, so one request may be issued every cycle.
// A load request (mode 0) writes one task slot and gives no result. A tick
// request (mode 1), while any slot is live, advances time by one and runs the
// highest-priority ready slot.
// Result channel: each tick gives one result on result, marked by strobe
// for a single cycle, once the request has passed valid_s1/req_s1 and then
// strobe_q/result_q. The receiver cannot stall; results are never held back.
// Throughput: one request per cycle, set by the single registered step in
// pps_core that picks the slot and updates the counters.
// Configuration: task_count at byte address 0 over the APB-style port,
// written only while no request is in flight (a rule on the user, not enforced).
// Reset: arst_n clears all slots, time and totals; task_count returns to 8.
module preemptive_priority_scheduler_top import pps_pkg::*; #(
	parameter int MAX_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        request,
	output logic        strobe,
	output rsp_t        result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic             valid_s1;
	req_t             req_s1;
	logic [CNT_W-1:0] task_count;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= request;
	end

	pps_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.task_count (task_count)
	);

	pps_core #(
		.MAX_TASKS (MAX_TASKS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.req_s1     (req_s1),
		.task_count (task_count),
		.strobe     (strobe),
		.result     (result)
	);

	a_tick_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.mode == MODE_TICK) |=> ##1 strobe)
		else $error("tick request did not produce a result");

	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && request.mode == MODE_LOAD) |=> ##1 !strobe)
		else $error("load request produced a result");

	a_finish_ran: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.finished) |-> (result.ran_valid && !$past(strobe && result.all_done)))
		else $error("finish reported without a running task");

endmodule

// File: rtl/core/pps_regs.sv
// APB-style configuration register of the scheduler (task_count).
// Depends on pps_pkg.
module pps_regs import pps_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [CNT_W-1:0] task_count
);

	logic [CNT_W-1:0] task_count_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_TASK_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= TASK_COUNT_RESET;
		end else if (wr_en) begin
			task_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_TASK_COUNT) begin
			prdata = {{(32-CNT_W){1'b0}}, task_count_q};
		end
	end

	assign task_count = task_count_q;

endmodule

// File: rtl/core/pps_core.sv
// Slot table, priority pick and counters; one registered step per request.
// Depends on pps_pkg.
module pps_core import pps_pkg::*; #(
	parameter int MAX_TASKS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  req_t             req_s1,
	input  logic [CNT_W-1:0] task_count,
	output logic             strobe,
	output rsp_t             result
);

	localparam int IDX_W = $clog2(MAX_TASKS);

	logic [7:0]         tag_q  [MAX_TASKS];
	logic [7:0]         pri_q  [MAX_TASKS];
	logic [15:0]        arr_q  [MAX_TASKS];
	logic [15:0]        rem_q  [MAX_TASKS];
	logic [TIME_W-1:0]  wait_q [MAX_TASKS];
	logic [MAX_TASKS-1:0] done_q;
	logic [TIME_W-1:0]  time_q;
	logic [TOTAL_W-1:0] wsum_q;
	logic [TOTAL_W-1:0] tsum_q;
	logic               strobe_q;
	rsp_t               result_q;

	logic [MAX_TASKS-1:0] live, ready, hit, live_after;
	logic                 found, fin, is_tick, is_load, go;
	logic [IDX_W-1:0]     best;
	logic [7:0]           best_pri;
	logic [TIME_W-1:0]    time_inc, wait_best, turn_best;
	logic [TOTAL_W:0]     wsum_add, tsum_add;
	logic [TOTAL_W-1:0]   wsum_next, tsum_next;
	logic [31:0]          best32;
	rsp_t                 rsp_d;

	assign is_tick = valid_s1 && (req_s1.mode == MODE_TICK);
	assign is_load = valid_s1 && (req_s1.mode == MODE_LOAD);

	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			live[i]  = (rem_q[i] != 16'd0) && !done_q[i] && ({28'd0, task_count} > 32'(i));
			ready[i] = live[i] && ({4'd0, arr_q[i]} <= time_q);
			hit[i]   = ({29'd0, req_s1.slot} == 32'(i));
		end
	end

	// lowest priority number wins, ascending scan keeps lowest slot on ties
	always_comb begin
		found    = 1'b0;
		best     = '0;
		best_pri = '0;
		for (int i = 0; i < MAX_TASKS; i++) begin
			if (ready[i] && (!found || pri_q[i] < best_pri)) begin
				found    = 1'b1;
				best     = IDX_W'(i);
				best_pri = pri_q[i];
			end
		end
	end

	assign go       = is_tick && (|live);
	assign time_inc = (time_q == TIME_MAX) ? time_q : time_q + 1'b1;
	assign fin      = found && (rem_q[best] == 16'd1);
	assign wait_best = wait_q[best];
	assign turn_best = time_inc - {4'd0, arr_q[best]};
	assign wsum_add  = {1'b0, wsum_q} + {5'd0, wait_best};
	assign tsum_add  = {1'b0, tsum_q} + {5'd0, turn_best};
	assign wsum_next = wsum_add[TOTAL_W] ? TOTAL_MAX : wsum_add[TOTAL_W-1:0];
	assign tsum_next = tsum_add[TOTAL_W] ? TOTAL_MAX : tsum_add[TOTAL_W-1:0];
	assign best32    = 32'(best);

	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			live_after[i] = live[i] && !(go && fin && (best == IDX_W'(i)));
		end
	end

	always_comb begin
		rsp_d                  = '0;
		rsp_d.time_now         = time_q;
		rsp_d.sum_wait         = wsum_q;
		rsp_d.sum_turnaround   = tsum_q;
		rsp_d.all_done         = !(|live_after);
		if (go) begin
			rsp_d.time_now = time_inc;
			if (found) begin
				rsp_d.ran_valid = 1'b1;
				rsp_d.ran_slot  = best32[2:0];
				rsp_d.ran_tag   = tag_q[best];
			end
			if (fin) begin
				rsp_d.finished         = 1'b1;
				rsp_d.wait_ticks       = wait_best;
				rsp_d.turnaround_ticks = turn_best;
				rsp_d.sum_wait         = wsum_next;
				rsp_d.sum_turnaround   = tsum_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				tag_q[i]  <= '0;
				pri_q[i]  <= '0;
				arr_q[i]  <= '0;
				rem_q[i]  <= '0;
				wait_q[i] <= '0;
			end
			done_q <= '0;
			time_q <= '0;
			wsum_q <= '0;
			tsum_q <= '0;
		end else begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				if (is_load && hit[i]) begin
					tag_q[i]  <= req_s1.task_tag;
					pri_q[i]  <= req_s1.task_priority;
					rem_q[i]  <= req_s1.burst_length;
					arr_q[i]  <= req_s1.arrival_tick;
					wait_q[i] <= '0;
					done_q[i] <= 1'b0;
				end else if (go && found) begin
					if (best == IDX_W'(i)) begin
						rem_q[i] <= rem_q[i] - 16'd1;
						if (fin) begin
							done_q[i] <= 1'b1;
						end
					end else if (ready[i] && wait_q[i] != TIME_MAX) begin
						wait_q[i] <= wait_q[i] + 1'b1;
					end
				end
			end
			if (go) begin
				time_q <= time_inc;
				if (fin) begin
					wsum_q <= wsum_next;
					tsum_q <= tsum_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= is_tick;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= rsp_d;
	end

	assign strobe = strobe_q;
	assign result = result_q;

endmodule

// File: tb/sv/pps_sched_sb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the preemptive priority scheduler testbench: a cycle-free
// predictor of the slot table, time and totals, plus the queue of expected tick reports.
// Depends on pps_pkg.
package pps_sched_sb_pkg;
	import pps_pkg::*;

	localparam int SLOTS = 8;

	class sched_scoreboard;
		logic [7:0]         tags [SLOTS];
		logic [7:0]         prios [SLOTS];
		logic [15:0]        arrivals [SLOTS];
		logic [15:0]        remain [SLOTS];
		logic [TIME_W-1:0]  waited [SLOTS];
		bit                 retired [SLOTS];
		logic [TIME_W-1:0]  clock_now;
		logic [TOTAL_W-1:0] wait_sum;
		logic [TOTAL_W-1:0] turn_sum;
		logic [CNT_W-1:0]   task_count;
		rsp_t               expected_reports [$];
		int                 mismatches;
		int                 strays;
		int                 loads;
		int                 ticks;
		int                 completions;
		int                 done_reports;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				tags[i] = '0;
				prios[i] = '0;
				arrivals[i] = '0;
				remain[i] = '0;
				waited[i] = '0;
				retired[i] = 1'b0;
			end
			clock_now = '0;
			wait_sum = '0;
			turn_sum = '0;
			task_count = TASK_COUNT_RESET;
		endfunction

		function void set_task_count(logic [CNT_W-1:0] value);
			task_count = value;
		endfunction

		function int in_use();
			return (task_count < SLOTS) ? int'(task_count) : SLOTS;
		endfunction

		function bit live(int i);
			return remain[i] != 0 && !retired[i];
		endfunction

		function bit all_finished();
			for (int i = 0; i < in_use(); i++)
				if (live(i))
					return 1'b0;
			return 1'b1;
		endfunction

		function bit ready(int i);
			return live(i) && TIME_W'(arrivals[i]) <= clock_now;
		endfunction

		function rsp_t tick_outcome();
			rsp_t o;
			int pick;
			logic [TOTAL_W:0] acc;
			o = '0;
			pick = -1;
			if (!all_finished()) begin
				for (int i = 0; i < in_use(); i++)
					if (ready(i) && (pick < 0 || prios[i] < prios[pick]))
						pick = i;
				if (pick >= 0) begin
					for (int i = 0; i < in_use(); i++)
						if (i != pick && ready(i) && waited[i] != TIME_MAX)
							waited[i] = waited[i] + 1'b1;
					o.ran_valid = 1'b1;
					o.ran_slot = 3'(pick);
					o.ran_tag = tags[pick];
					remain[pick] = remain[pick] - 1'b1;
				end
				if (clock_now != TIME_MAX)
					clock_now = clock_now + 1'b1;
				if (pick >= 0 && remain[pick] == 0) begin
					retired[pick] = 1'b1;
					o.finished = 1'b1;
					o.wait_ticks = waited[pick];
					o.turnaround_ticks = clock_now - TIME_W'(arrivals[pick]);
					acc = wait_sum + o.wait_ticks;
					wait_sum = (acc > TOTAL_MAX) ? TOTAL_MAX : acc[TOTAL_W-1:0];
					acc = turn_sum + o.turnaround_ticks;
					turn_sum = (acc > TOTAL_MAX) ? TOTAL_MAX : acc[TOTAL_W-1:0];
					completions++;
				end
			end
			o.all_done = all_finished();
			if (o.all_done)
				done_reports++;
			o.time_now = clock_now;
			o.sum_wait = wait_sum;
			o.sum_turnaround = turn_sum;
			return o;
		endfunction

		function void note_request(req_t r);
			if (r.mode == MODE_LOAD) begin
				loads++;
				if (r.slot < SLOTS) begin
					tags[r.slot] = r.task_tag;
					prios[r.slot] = r.task_priority;
					remain[r.slot] = r.burst_length;
					arrivals[r.slot] = r.arrival_tick;
					waited[r.slot] = '0;
					retired[r.slot] = 1'b0;
				end
			end else begin
				ticks++;
				expected_reports.push_back(tick_outcome());
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		function bit field_ok(string name, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
			if (got === want)
				return 1'b1;
			if (mismatches < 10)
				$display("tick report %0d: %s expected %0h, got %0h",
					ticks - expected_reports.size(), name, want, got);
			return 1'b0;
		endfunction

		function void check_report(rsp_t got);
			rsp_t want;
			bit ok;
			if (expected_reports.size() == 0) begin
				strays++;
				if (strays + mismatches <= 10)
					$display("unexpected tick report %h", got);
				return;
			end
			want = expected_reports.pop_front();
			ok = 1'b1;
			ok = field_ok("ran_valid", want.ran_valid, got.ran_valid) & ok;
			ok = field_ok("ran_slot", want.ran_slot, got.ran_slot) & ok;
			ok = field_ok("ran_tag", want.ran_tag, got.ran_tag) & ok;
			ok = field_ok("finished", want.finished, got.finished) & ok;
			ok = field_ok("wait_ticks", want.wait_ticks, got.wait_ticks) & ok;
			ok = field_ok("turnaround_ticks", want.turnaround_ticks, got.turnaround_ticks) & ok;
			ok = field_ok("all_done", want.all_done, got.all_done) & ok;
			ok = field_ok("time_now", want.time_now, got.time_now) & ok;
			ok = field_ok("sum_wait", want.sum_wait, got.sum_wait) & ok;
			ok = field_ok("sum_turnaround", want.sum_turnaround, got.sum_turnaround) & ok;
			if (!ok)
				mismatches++;
		endfunction
	endclass

endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, request and APB drivers, directed
// and random phases, checked through the scoreboard in pps_sched_sb_pkg.
// Depends on pps_pkg, pps_sched_sb_pkg and preemptive_priority_scheduler_top.
module tb_top;
	import pps_pkg::*;
	import pps_sched_sb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        request;
	logic        strobe;
	rsp_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	logic        report_seen;
	rsp_t        report_data;
	bit          steady;
	int unsigned sent;

	sched_scoreboard sb = new();

	preemptive_priority_scheduler_top #(.MAX_TASKS(SLOTS)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.strobe(strobe),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("preemptive_priority_scheduler_top test failed");
		$finish;
	end

	// results are registered at the rising edge and checked on the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_seen <= 1'b0;
			report_data <= '0;
		end else begin
			report_seen <= strobe;
			report_data <= result;
		end
	end

	always @(negedge clk) begin
		if (report_seen)
			sb.check_report(report_data);
	end

	task automatic put_request(input req_t r);
		if (!steady && $urandom_range(0, 99) < 10) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		request <= r;
		start <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(r);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_task_count(input logic [CNT_W-1:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {REG_TASK_COUNT, 2'b00};
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_task_count(value);
	endtask

	function automatic req_t load_req(input logic [2:0] slot, input logic [7:0] tag,
		input logic [7:0] prio, input logic [15:0] burst, input logic [15:0] arrival);
		req_t r;
		r.mode = MODE_LOAD;
		r.slot = slot;
		r.task_tag = tag;
		r.task_priority = prio;
		r.burst_length = burst;
		r.arrival_tick = arrival;
		return r;
	endfunction

	// payload of a tick is don't-care, so it is filled at random
	function automatic req_t tick_req();
		req_t r;
		r = req_t'({$urandom, $urandom});
		r.mode = MODE_TICK;
		return r;
	endfunction

	function automatic req_t random_load();
		logic [7:0]  prio;
		logic [15:0] burst;
		int unsigned pick;
		prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 8)
			burst = '0;
		else if (pick < 12)
			burst = 16'($urandom_range(0, 65535));
		else
			burst = 16'($urandom_range(1, 6));
		return load_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), prio, burst,
			sb.clock_now[15:0] + 16'($urandom_range(0, 6)));
	endfunction

	task automatic directed_checks();
		put_request(tick_req());
		put_request(load_req(3'd0, 8'hFF, 8'hFF, 16'd2, 16'd3));
		repeat (5) put_request(tick_req());
		put_request(load_req(3'd1, 8'h00, 8'h00, 16'd3, 16'd0));
		put_request(load_req(3'd2, 8'h5A, 8'h10, 16'd2, 16'd0));
		put_request(load_req(3'd6, 8'h66, 8'h10, 16'd1, 16'd0));
		put_request(load_req(3'd3, 8'hA5, 8'h10, 16'hFFFF, 16'hFFFF));
		repeat (4) put_request(tick_req());
		// higher priority arrives while slot 2 is mid-burst
		put_request(load_req(3'd4, 8'h3C, 8'h01, 16'd1, sb.clock_now[15:0]));
		repeat (4) put_request(tick_req());
		put_request(load_req(3'd3, 8'hC3, 8'hEE, 16'd0, 16'd0));
		put_request(tick_req());
		drain();
		write_task_count(4'd0);
		put_request(load_req(3'd7, 8'h81, 8'h7F, 16'd1, 16'd0));
		put_request(tick_req());
		drain();
		write_task_count(4'd15);
		put_request(tick_req());
	endtask

	task automatic run_batch();
		int unsigned budget;
		int unsigned pick;
		req_t r;
		steady = (sent >= 275 && sent < 445);
		if ($urandom_range(0, 3) == 0) begin
			drain();
			case ($urandom_range(0, 5))
				0: write_task_count(4'd0);
				1: write_task_count(4'd1);
				2: write_task_count(4'd8);
				3: write_task_count(4'd15);
				default: write_task_count(4'($urandom_range(1, 8)));
			endcase
		end
		budget = $urandom_range(2, 8);
		repeat ($urandom_range(1, 8)) begin
			r = random_load();
			budget += (r.burst_length > 12) ? 12 : r.burst_length;
			put_request(r);
		end
		repeat (budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				put_request(random_load());
			else if (pick < 12)
				put_request(req_t'({$urandom, $urandom}));
			else
				put_request(tick_req());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		sent = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		directed_checks();
		while (sent < 660)
			run_batch();
		steady = 1'b0;
		drain();
		$display("Covered %0d loads and %0d ticks across task counts 0 to 15, ties and preemption.",
			sb.loads, sb.ticks);
		$display("%0d tasks completed and %0d all-done reports seen.",
			sb.completions, sb.done_reports);
		if (sb.mismatches == 0 && sb.strays == 0 && sb.pending() == 0) begin
			$display("preemptive_priority_scheduler_top test passed");
		end else begin
			$display("preemptive_priority_scheduler_top test failed");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/core/pps_pkg.sv
rtl/core/pps_regs.sv
rtl/core/pps_core.sv
rtl/core/preemptive_priority_scheduler_top.sv
tb/sv/pps_sched_sb_pkg.sv
tb/sv/tb_top.sv
